// ----- hdl/lbcd_pkg.sv -----
// Package: shared types, codes and sizes for the LRU block cache directory.
`timescale 1ns / 1ps

package lbcd_pkg;

    localparam int ENTRIES = 64;
    localparam int SLOT_W  = $clog2(ENTRIES);

    localparam int KEY_W    = 64;
    localparam int COUNT_W  = 32;
    localparam int EBYTES_W = 4;
    localparam int STAMP_W  = 32;
    localparam int SIZE_W   = 35;
    localparam int TOTAL_W  = 41;
    localparam int OSLOT_W  = 6;

    localparam logic [EBYTES_W-1:0] MAX_EBYTES = EBYTES_W'(8);

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_MISS  = 3'd1,
        ST_FULL  = 3'd2,
        ST_DUP   = 3'd3,
        ST_EMPTY = 3'd4
    } t_status;

    typedef struct packed {
        t_action               action;
        logic [KEY_W-1:0]      key;
        logic [COUNT_W-1:0]    elem_count;
        logic [EBYTES_W-1:0]   elem_bytes;
    } t_in_beat;

    typedef struct packed {
        t_status               status;
        logic [OSLOT_W-1:0]    slot;
        logic [KEY_W-1:0]      evicted_key;
        logic [SIZE_W-1:0]     evicted_size;
        logic [TOTAL_W-1:0]    total_bytes;
    } t_out_beat;

    // One directory entry as it is kept in memory.
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [STAMP_W-1:0]    stamp;
        logic [SIZE_W-1:0]     size;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Reports a slot index modulo 64, whatever the table depth.
    function automatic logic [OSLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+OSLOT_W-1:0] wide;
        wide = {{OSLOT_W{1'b0}}, idx};
        return wide[OSLOT_W-1:0];
    endfunction

endpackage

// ----- hdl/lbcd_ram.sv -----
// Module: simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module lbcd_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lru_block_cache_directory.sv -----
// Module: top level of the LRU block cache directory (scan engine and control).
//
// Channel   Direction  Handshake                 Beat type
// -------   ---------  ------------------------  ----------------------
// in        input      i_in_valid / o_in_stall   lbcd_pkg::t_in_beat
// out       output     o_out_valid / i_out_stall lbcd_pkg::t_out_beat
//
// Lookup, add and remove each sweep the whole entry memory, one read per cycle;
// the single read port of the entry memory sets the length of a command. Clear
// skips the sweep and goes straight to the finish state.
// Reset is synchronous and active low; it clears the valid bits, the use counter
// and the byte total, and needs no sweep of the memory.
// The input stalls while a command is in progress; a finished result waits in
// the output register, and the next command may be taken while it waits.
`timescale 1ns / 1ps

module lru_block_cache_directory (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lbcd_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lbcd_pkg::t_out_beat o_out_beat
);

    import lbcd_pkg::*;

    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state;

    // Command held for the duration of the sweep.
    t_in_beat             r_cmd;
    logic [SIZE_W-1:0]    r_size;

    // Sweep control: read issue, and the compare stage that follows it in the next cycle.
    logic [SLOT_W-1:0]    r_addr;
    logic                 r_issue;
    logic                 r_cmp_vld;
    logic                 r_cmp_last;
    logic [SLOT_W-1:0]    r_cmp_idx;

    // Sweep results.
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_sel_idx;
    logic [KEY_W-1:0]     r_sel_key;
    logic [STAMP_W-1:0]   r_sel_stamp;
    logic [SIZE_W-1:0]    r_sel_size;
    logic                 r_free;
    logic [SLOT_W-1:0]    r_free_idx;

    // Architectural state held in flops.
    logic [ENTRIES-1:0]   r_valid;
    logic [STAMP_W-1:0]   r_use_cnt;
    logic [TOTAL_W-1:0]   r_total;

    logic                 r_out_valid;
    t_out_beat            r_out;

    // Entry memory ports.
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    t_entry               ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    t_entry               rd_entry;

    logic                 in_acc;
    logic                 fin_go;
    logic [EBYTES_W-1:0]  eb_clamped;
    logic [SIZE_W:0]      size_prod;
    logic                 cmp_valid;

    t_out_beat            n_out;
    logic [TOTAL_W-1:0]   n_total;
    logic [ENTRIES-1:0]   n_valid;
    logic                 n_bump;

    lbcd_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign fin_go      = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Element widths above eight count as eight; the product is only 32 x 4 bits.
    assign eb_clamped = (i_in_beat.elem_bytes > MAX_EBYTES) ? MAX_EBYTES
                                                              : i_in_beat.elem_bytes;
    assign size_prod  = (SIZE_W + 1)'(i_in_beat.elem_count) * (SIZE_W + 1)'(eb_clamped);

    assign cmp_valid = r_valid[r_cmp_idx];

    // Outcome of a command once its sweep, if it has one, has finished.
    always_comb begin
        n_out       = '0;
        n_out.status = ST_OK;
        n_total     = r_total;
        n_valid     = r_valid;
        n_bump      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_sel_idx;
        ram_wdata   = '{key: r_cmd.key, stamp: r_use_cnt, size: r_sel_size};
        case (r_cmd.action)
            ACT_LOOKUP: begin
                if (r_hit) begin
                    ram_we     = fin_go;
                    n_bump     = 1'b1;
                    n_out.slot = slot_of(r_sel_idx);
                end else begin
                    n_out.status = ST_MISS;
                end
            end
            ACT_ADD: begin
                if (r_hit) begin
                    n_out.status = ST_DUP;
                end else if (!r_free) begin
                    n_out.status = ST_FULL;
                end else begin
                    ram_we             = fin_go;
                    ram_waddr          = r_free_idx;
                    ram_wdata.size     = r_size;
                    n_bump             = 1'b1;
                    n_valid[r_free_idx] = 1'b1;
                    n_total            = r_total + TOTAL_W'(r_size);
                    n_out.slot         = slot_of(r_free_idx);
                end
            end
            ACT_REMOVE: begin
                if (r_hit) begin
                    n_valid[r_sel_idx] = 1'b0;
                    n_total            = r_total - TOTAL_W'(r_sel_size);
                    n_out.slot         = slot_of(r_sel_idx);
                    n_out.evicted_key  = r_sel_key;
                    n_out.evicted_size = r_sel_size;
                end else begin
                    n_out.status = ST_EMPTY;
                end
            end
            ACT_CLEAR: begin
                n_valid = '0;
                n_total = '0;
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
        n_out.total_bytes = n_total;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_cmp_last  <= 1'b0;
            r_valid     <= '0;
            r_use_cnt   <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result loads the output register; a held one stays until taken.
            r_out_valid <= fin_go || (r_out_valid && i_out_stall);
            r_cmp_vld  <= r_issue;
            r_cmp_last <= r_issue && (r_addr == LAST);
            if (r_issue && (r_addr == LAST)) begin
                r_issue <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_beat.action == ACT_CLEAR) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SCAN;
                            r_issue <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cmp_vld && r_cmp_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_state     <= S_IDLE;
                        r_valid     <= n_valid;
                        r_total     <= n_total;
                        if (n_bump) begin
                            r_use_cnt <= r_use_cnt + STAMP_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Command capture, sweep datapath and result register.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_in_beat;
            r_size <= size_prod[SIZE_W-1:0];
            r_addr <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (r_issue && (r_addr != LAST)) begin
                r_addr <= r_addr + SLOT_W'(1);
            end
            if (r_cmp_vld) begin
                if (r_cmd.action == ACT_REMOVE) begin
                    // Strictly smaller stamp wins, so the lowest slot keeps a tie.
                    if (cmp_valid && (!r_hit || (rd_entry.stamp < r_sel_stamp))) begin
                        r_hit       <= 1'b1;
                        r_sel_idx   <= r_cmp_idx;
                        r_sel_key   <= rd_entry.key;
                        r_sel_stamp <= rd_entry.stamp;
                        r_sel_size  <= rd_entry.size;
                    end
                end else begin
                    if (cmp_valid && !r_hit && (rd_entry.key == r_cmd.key)) begin
                        r_hit      <= 1'b1;
                        r_sel_idx  <= r_cmp_idx;
                        r_sel_size <= rd_entry.size;
                    end
                    if (!cmp_valid && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_cmp_idx;
                    end
                end
            end
        end
        r_cmp_idx <= r_addr;
        if (fin_go) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- hdl/lbcd_checker.sv -----
// Module: port-level checker for the LRU block cache directory, with its bind.
`timescale 1ns / 1ps

module lbcd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input lbcd_pkg::t_in_beat  i_in_beat,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lbcd_pkg::t_out_beat o_out_beat
);

    import lbcd_pkg::*;

    // A result held back by the consumer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled result beat changed");

    // Commands are handled one at a time, so an accepted beat stalls the next.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a beat");

    // Failed commands report no slot and no eviction.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status != ST_OK) |->
            (o_out_beat.slot == '0) && (o_out_beat.evicted_key == '0) &&
            (o_out_beat.evicted_size == '0))
        else $error("failed command reported slot or eviction");

    // An empty table holds no bytes.
    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status == ST_EMPTY) |-> (o_out_beat.total_bytes == '0))
        else $error("empty table with nonzero byte total");

endmodule

bind lru_block_cache_directory lbcd_checker u_lbcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

// ----- verif/lbcd_directory_checker.sv -----
// Checker: tracks the cache directory contents and compares each result beat with its prediction.
`timescale 1ns / 1ps

module lbcd_directory_checker
    import lbcd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_beat,
    output int        o_pending,
    output int        o_fail_count
);

    // Shadow copy of the directory.
    bit                  dir_valid [ENTRIES];
    bit [KEY_W-1:0]      dir_key   [ENTRIES];
    bit [STAMP_W-1:0]    dir_stamp [ENTRIES];
    bit [SIZE_W-1:0]     dir_size  [ENTRIES];
    bit [STAMP_W-1:0]    use_count;
    bit [TOTAL_W-1:0]    held_bytes;

    t_out_beat           pending_replies[$];
    int                  mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic int find_entry(input logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++) begin
            if (dir_valid[i] && dir_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one command to the shadow directory and returns the reply it should produce.
    function automatic t_out_beat apply_command(input t_in_beat cmd);
        t_out_beat           res;
        int                  hit;
        int                  pick;
        logic [EBYTES_W-1:0] width;
        logic [SIZE_W:0]     product;
        res = '0;
        res.status = ST_OK;
        hit = find_entry(cmd.key);
        pick = -1;
        case (cmd.action)
            ACT_LOOKUP: begin
                if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    dir_stamp[hit] = use_count;
                    use_count = use_count + STAMP_W'(1);
                    res.slot = OSLOT_W'(hit);
                end
            end
            ACT_ADD: begin
                width = (cmd.elem_bytes > MAX_EBYTES) ? MAX_EBYTES : cmd.elem_bytes;
                if (hit >= 0) begin
                    res.status = ST_DUP;
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!dir_valid[i] && pick < 0) begin
                            pick = i;
                        end
                    end
                    if (pick < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        // The product is sized by the 36-bit target, so it cannot overflow.
                        product = cmd.elem_count * width;
                        dir_valid[pick] = 1'b1;
                        dir_key[pick]   = cmd.key;
                        dir_stamp[pick] = use_count;
                        dir_size[pick]  = product[SIZE_W-1:0];
                        use_count  = use_count + STAMP_W'(1);
                        held_bytes = held_bytes + TOTAL_W'(dir_size[pick]);
                        res.slot = OSLOT_W'(pick);
                    end
                end
            end
            ACT_REMOVE: begin
                // Oldest stamp wins; strict compare keeps the lowest slot on a tie.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (dir_valid[i] && (pick < 0 || dir_stamp[i] < dir_stamp[pick])) begin
                        pick = i;
                    end
                end
                if (pick < 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.evicted_key  = dir_key[pick];
                    res.evicted_size = dir_size[pick];
                    held_bytes = held_bytes - TOTAL_W'(dir_size[pick]);
                    dir_valid[pick] = 1'b0;
                    res.slot = OSLOT_W'(pick);
                end
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    dir_valid[i] = 1'b0;
                end
                held_bytes = '0;
            end
        endcase
        res.total_bytes = held_bytes;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                dir_valid[i] = 1'b0;
            end
            use_count  = '0;
            held_bytes = '0;
            pending_replies.delete();
        end else begin
            // Retire the result first: it can never belong to a command taken at this edge.
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    $error("result beat with no command outstanding: 0x%0h", i_out_beat);
                    mismatch_count++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status", want.status, i_out_beat.status);
                    check_field("slot", want.slot, i_out_beat.slot);
                    check_field("evicted_key", want.evicted_key, i_out_beat.evicted_key);
                    check_field("evicted_size", want.evicted_size, i_out_beat.evicted_size);
                    check_field("total_bytes", want.total_bytes, i_out_beat.total_bytes);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_replies.insert(pending_replies.size(), apply_command(i_in_beat));
            end
        end
        o_pending <= pending_replies.size();
    end

endmodule

// ----- verif/tb.sv -----
// Testbench top: drives commands into the cache directory and gives the verdict.
`timescale 1ns / 1ps

module tb;
    import lbcd_pkg::*;

    // Generous bound on the run, enough for a correct run even with every beat hit
    // by the longest sender gap and receiver stall.
    localparam int LIMIT      = 1000000;
    localparam int NUM_RANDOM = 430;
    localparam int KEY_POOL   = 96;

    // Traffic mixes for the random part. A fill mix pushes the table toward
    // full, a drain mix toward empty, and the balanced mix keeps it in between.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    t_in_beat  in_beat  = '0;
    logic      out_stall = 1'b0;
    logic      dut_in_stall;
    logic      dut_out_valid;
    t_out_beat dut_out_beat;
    int        pending;
    int        fail_count;
    int        cycles = 0;

    // When set, the sender puts no gaps between beats.
    bit        calm = 1'b0;

    // Keys drawn from a small pool so that lookups hit and adds collide.
    logic [KEY_W-1:0] key_pool [KEY_POOL];

    always #10 clk = ~clk;

    // Synchronous reset, asserted from time zero and never asserted again.
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    lru_block_cache_directory i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (dut_in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (dut_out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (dut_out_beat)
    );

    lbcd_directory_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (dut_in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (dut_out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (dut_out_beat),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("FAIL lru_block_cache_directory");
            $finish;
        end
    end

    // Receiver stalls. Free stretches alternate with stalls; most stalls end well
    // before a command does, some cover a whole command, and now and then a long
    // free stretch lets results stream out with no back pressure.
    initial begin : receiver
        int free_run;
        int hold;
        forever begin
            free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                   : $urandom_range(1, 30);
            repeat (free_run) @(posedge clk);
            out_stall <= 1'b1;
            hold = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100)
                                               : $urandom_range(1, 4);
            repeat (hold) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // Idle cycles before the next beat. Most gaps are short; a few are long
    // enough to land anywhere in the scan of a command.
    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 35) begin
            return 0;
        end
        if (roll < 75) begin
            return $urandom_range(1, 8);
        end
        if (roll < 95) begin
            return $urandom_range(9, 80);
        end
        return $urandom_range(81, 150);
    endfunction

    // Presents one command beat and returns at the edge where it is taken.
    // Valid is only dropped when a gap follows, so back-to-back beats keep it
    // high with a single assignment per edge.
    task automatic send_cmd(input t_action act, input logic [KEY_W-1:0] key,
                            input logic [COUNT_W-1:0] count,
                            input logic [EBYTES_W-1:0] ebytes);
        t_in_beat beat;
        int       gap;
        beat.action     = act;
        beat.key        = key;
        beat.elem_count = count;
        beat.elem_bytes = ebytes;
        gap = sender_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (dut_in_stall) begin
            @(posedge clk);
        end
    endtask

    // Holds the sender off until every result has come back. The first edge
    // lets the checker count the beat that was taken at the current one.
    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    initial begin : stimulus
        int               sent;
        int               span;
        int               roll;
        t_mix             mix;
        t_action          act;
        logic [KEY_W-1:0] key;
        logic [EBYTES_W-1:0] ebytes;

        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i] = random_key();
        end

        while (!rst_n) begin
            @(posedge clk);
        end

        // Directed part. The table starts empty, so remove reports empty and
        // lookup misses. Keys of all zeros and all ones, the largest block
        // size, and element widths of zero, odd values and above eight follow.
        send_cmd(ACT_REMOVE, '0, '0, 4'd1);
        send_cmd(ACT_LOOKUP, '0, '0, 4'd1);
        send_cmd(ACT_ADD, '0, '1, 4'd8);
        send_cmd(ACT_ADD, '1, '1, 4'd15);
        send_cmd(ACT_ADD, '0, 32'd12, 4'd4);
        send_cmd(ACT_ADD, 64'h0123_4567_89ab_cdef, 32'd1000, 4'd0);
        send_cmd(ACT_ADD, 64'h0000_0000_0000_0002, 32'd7, 4'd3);
        send_cmd(ACT_ADD, 64'h0000_0000_0000_0003, 32'd5, 4'd1);
        send_cmd(ACT_ADD, 64'h0000_0000_0000_0004, 32'd9, 4'd2);
        send_cmd(ACT_ADD, 64'h8000_0000_0000_0000, 32'd11, 4'd5);
        send_cmd(ACT_ADD, 64'h8000_0000_0000_0001, 32'd13, 4'd6);
        send_cmd(ACT_ADD, 64'h7fff_ffff_ffff_ffff, 32'hffff_fffe, 4'd7);
        // Refresh the two oldest entries so the eviction order changes.
        send_cmd(ACT_LOOKUP, '0, '0, 4'd1);
        send_cmd(ACT_LOOKUP, '1, '0, 4'd1);
        send_cmd(ACT_LOOKUP, 64'hdead_beef_0000_0001, '0, 4'd1);
        send_cmd(ACT_REMOVE, '0, '0, 4'd1);
        send_cmd(ACT_REMOVE, '1, '1, 4'd15);
        // Clear must empty the table and zero the byte total.
        send_cmd(ACT_CLEAR, '0, '0, 4'd1);
        send_cmd(ACT_LOOKUP, '0, '0, 4'd1);
        send_cmd(ACT_REMOVE, '0, '0, 4'd1);
        send_cmd(ACT_ADD, 64'h5555_5555_5555_5555, 32'h5555_5555, 4'd9);
        send_cmd(ACT_ADD, 64'haaaa_aaaa_aaaa_aaaa, 32'haaaa_aaaa, 4'd10);
        send_cmd(ACT_LOOKUP, 64'h5555_5555_5555_5555, '0, 4'd1);
        send_cmd(ACT_CLEAR, '1, '1, 4'd15);
        drain_replies();

        // Fill the table with fresh keys of the largest size, then keep
        // adding so that full-table rejections are seen.
        calm = 1'b1;
        for (int i = 0; i < ENTRIES + 3; i++) begin
            send_cmd(ACT_ADD, random_key(), '1, 4'd8);
        end
        calm = 1'b0;
        send_cmd(ACT_ADD, random_key(), $urandom, 4'd2);
        drain_replies();
        send_cmd(ACT_CLEAR, '0, '0, 4'd1);

        // Random part, in phases of one traffic mix each.
        sent = 0;
        while (sent < NUM_RANDOM) begin
            mix  = t_mix'($urandom_range(0, 2));
            span = $urandom_range(10, 60);
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < span && sent < NUM_RANDOM; n++) begin
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL: begin
                        act = (roll < 65) ? ACT_ADD : (roll < 90) ? ACT_LOOKUP :
                              (roll < 99) ? ACT_REMOVE : ACT_CLEAR;
                    end
                    MIX_DRAIN: begin
                        act = (roll < 55) ? ACT_REMOVE : (roll < 85) ? ACT_LOOKUP :
                              (roll < 99) ? ACT_ADD : ACT_CLEAR;
                    end
                    default: begin
                        act = (roll < 40) ? ACT_LOOKUP : (roll < 70) ? ACT_ADD :
                              (roll < 98) ? ACT_REMOVE : ACT_CLEAR;
                    end
                endcase
                key = ($urandom_range(0, 3) == 0) ? random_key()
                                                  : key_pool[$urandom_range(0, KEY_POOL - 1)];
                ebytes = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'(1 << $urandom_range(0, 3));
                send_cmd(act, key, $urandom, ebytes);
                sent++;
            end
            // Now and then let the whole pipeline empty before the next phase.
            if ($urandom_range(0, 4) == 0) begin
                drain_replies();
            end
        end
        calm = 1'b0;

        // Wait for the last results, then long enough for a stray extra
        // beat to show up before the verdict.
        drain_replies();
        repeat (ENTRIES + 8) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS lru_block_cache_directory");
        end else begin
            $display("FAIL lru_block_cache_directory");
        end
        $finish;
    end

endmodule
